FILE: hw/rtl/fwrs_pkg.sv
// Shared constants, codes and types for the queue with running statistics.
// No dependencies; every other file in hw/rtl imports this package.
package fwrs_pkg;

  // Queue geometry and field widths.
  localparam int unsigned Depth  = 64;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = AddrW + 1;
  localparam int unsigned ValW   = 16;
  localparam int unsigned SumW   = ValW + AddrW;
  localparam int unsigned StatW  = 2;
  localparam int unsigned StepW  = $clog2(SumW);

  // Operation carried by an input beat.
  typedef enum logic {
    OpPush = 1'b0,
    OpPop  = 1'b1
  } opcode_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Request to the serial divider.
  typedef struct packed {
    logic                   start;
    logic signed [SumW-1:0] dividend;
    logic        [CntW-1:0] divisor;
  } div_req_t;

  // Response from the serial divider.
  typedef struct packed {
    logic                   done;
    logic signed [ValW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/fwrs_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on fwrs_pkg for field widths and codes.
interface fwrs_in_if;
  import fwrs_pkg::*;

  logic                   valid;
  logic                   ready;
  opcode_e                opcode;
  logic signed [ValW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface fwrs_out_if;
  import fwrs_pkg::*;

  logic                   valid;
  logic                   ready;
  status_e                status;
  logic signed [ValW-1:0] popped_value;
  logic        [CntW-1:0] item_count;
  logic signed [SumW-1:0] total_sum;
  logic signed [ValW-1:0] mean_value;
  logic signed [ValW-1:0] largest;
  logic signed [ValW-1:0] smallest;

  modport source (output valid, output status, output popped_value, output item_count,
                  output total_sum, output mean_value, output largest, output smallest,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input item_count,
                  input total_sum, input mean_value, input largest, input smallest,
                  output ready);
endinterface

FILE: hw/rtl/fwrs_div.sv
// Restoring serial divider: signed sum over unsigned nonzero count, one
// quotient bit per cycle, truncated toward zero. Depends on fwrs_pkg.
module fwrs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwrs_pkg::div_req_t req_i,
  output fwrs_pkg::div_rsp_t rsp_o
);
  import fwrs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [CntW-1:0]   dvs_q, dvs_d;
  logic [CntW:0]     trial;
  logic [CntW:0]     diff;
  logic [SumW-1:0]   mag;
  logic [SumW-1:0]   signed_quo;

  // Magnitude of the dividend; the sign is restored at the end.
  assign mag = req_i.dividend[SumW-1] ? SumW'(-req_i.dividend) : SumW'(req_i.dividend);

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[SumW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.dividend[SumW-1];
      step_d = '0;
      rem_d  = '0;
      quo_d  = mag;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[CntW]) begin
        rem_d = diff[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
  end

  // The quotient magnitude never exceeds the value range, so truncation is safe.
  assign signed_quo     = neg_q ? SumW'(-quo_q) : quo_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = signed_quo[ValW-1:0];

endmodule

FILE: hw/rtl/fifo_with_running_statistics.sv
// Top level: 64-entry queue of signed Q8.8 values with count, sum, mean,
// largest and smallest. Depends on fwrs_pkg, fwrs_if and fwrs_div.
//
//   Channel  Direction  Beat carries
//   in_i     sink       opcode, value
//   out_o    source     status, popped_value, item_count, total_sum,
//                       mean_value, largest, smallest
//
// One item is worked at a time. A push, accepted or refused as full, waits on
// the 22-step serial divider that forms the mean. A pop that leaves entries in
// the queue reads the slot memory once per held entry to rebuild largest and
// smallest, then the divider runs. A pop from an empty queue, or a pop that
// empties it, runs no division.
// After reset the queue is empty and the block takes an item at once.
// A new item may be taken while the previous result waits in the output
// register; a stalled output holds the next result in the final state.
module fifo_with_running_statistics (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwrs_in_if.sink    in_i,
  fwrs_out_if.source out_o
);
  import fwrs_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPop  = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SDivS = 3'd3;
  localparam logic [2:0] SDivW = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [AddrW-1:0]       head_q, head_d;
  logic [AddrW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [ValW-1:0] max_q, max_d;
  logic signed [ValW-1:0] min_q, min_d;
  logic signed [ValW-1:0] mean_q, mean_d;
  status_e                st_q, st_d;
  logic signed [ValW-1:0] pop_q, pop_d;
  logic [CntW-1:0]        iss_q, iss_d;
  logic [CntW-1:0]        rcv_q, rcv_d;
  logic                   rv_q, rv_d;
  logic                   ov_q;
  logic                   load;
  logic                   in_fire;

  // Slot memory with a registered read port.
  logic signed [ValW-1:0] mem_q [Depth];
  logic signed [ValW-1:0] rd_q;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic                   wr_en;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_i.ready = (state_q == SIdle);
  assign in_fire    = in_i.valid && in_i.ready;

  // Sequencer: update on push, read-modify on pop, rescan, then divide.
  always_comb begin
    state_d          = state_q;
    head_d           = head_q;
    tail_d           = tail_q;
    cnt_d            = cnt_q;
    sum_d            = sum_q;
    max_d            = max_q;
    min_d            = min_q;
    mean_d           = mean_q;
    st_d             = st_q;
    pop_d            = pop_q;
    iss_d            = iss_q;
    rcv_d            = rcv_q;
    rd_en            = 1'b0;
    rd_addr          = head_q;
    wr_en            = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = cnt_q;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          st_d    = StOk;
          pop_d   = '0;
          state_d = SDivS;
          if (in_i.opcode == OpPush) begin
            if (cnt_q == CntW'(Depth)) begin
              st_d = StFull;
            end else begin
              wr_en  = 1'b1;
              tail_d = tail_q + AddrW'(1);
              cnt_d  = cnt_q + CntW'(1);
              sum_d  = sum_q + SumW'(in_i.value);
              if (cnt_q == '0 || in_i.value > max_q) max_d = in_i.value;
              if (cnt_q == '0 || in_i.value < min_q) min_d = in_i.value;
            end
          end else begin
            if (cnt_q == '0) begin
              st_d = StEmpty;
            end else begin
              rd_en   = 1'b1;
              state_d = SPop;
            end
          end
        end
      end
      SPop: begin
        pop_d  = rd_q;
        head_d = head_q + AddrW'(1);
        cnt_d  = cnt_q - CntW'(1);
        iss_d  = '0;
        rcv_d  = '0;
        if (cnt_q == CntW'(1)) begin
          sum_d   = '0;
          max_d   = '0;
          min_d   = '0;
          state_d = SDivS;
        end else begin
          sum_d   = sum_q - SumW'(rd_q);
          state_d = SScan;
        end
      end
      SScan: begin
        // Issue one read per cycle; the data returns in the next cycle.
        if (iss_q != cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = head_q + iss_q[AddrW-1:0];
          iss_d   = iss_q + CntW'(1);
        end
        if (rv_q) begin
          if (rcv_q == '0) begin
            max_d = rd_q;
            min_d = rd_q;
          end else begin
            if (rd_q > max_q) max_d = rd_q;
            if (rd_q < min_q) min_d = rd_q;
          end
          rcv_d = rcv_q + CntW'(1);
          if (rcv_q + CntW'(1) == cnt_q) state_d = SDivS;
        end
      end
      SDivS: begin
        if (cnt_q == '0) begin
          mean_d  = '0;
          state_d = SDone;
        end else begin
          div_req.start = 1'b1;
          state_d       = SDivW;
        end
      end
      SDivW: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quotient;
          state_d = SDone;
        end
      end
      SDone: begin
        if (!ov_q || out_o.ready) begin
          load    = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign rv_d = rd_en && (state_q == SScan);

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      rv_q    <= rv_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    st_q   <= st_d;
    pop_q  <= pop_d;
    iss_q  <= iss_d;
    rcv_q  <= rcv_d;
  end

  // Slot memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= in_i.value;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.status       <= st_q;
      out_o.popped_value <= pop_q;
      out_o.item_count   <= cnt_q;
      out_o.total_sum    <= sum_q;
      out_o.mean_value   <= mean_q;
      out_o.largest      <= max_q;
      out_o.smallest     <= min_q;
    end
  end

  assign out_o.valid = ov_q;

  fwrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Head, tail and count stay consistent around the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q + cnt_q[AddrW-1:0]) == tail_q)
    else $error("queue pointers disagree with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("count above queue depth");

  // An empty queue reports all statistics as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone && cnt_q == '0) |->
      (sum_q == '0 && max_q == '0 && min_q == '0 && mean_q == '0))
    else $error("nonzero statistics on empty queue");

  // A rejected item never reports a popped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_o.status != StOk) |-> (out_o.popped_value == '0))
    else $error("popped value on rejected item");

  // The divider is only started with a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (cnt_q != '0))
    else $error("divide by zero count");

  // Largest never falls below smallest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (max_q >= min_q))
    else $error("largest below smallest");

endmodule

FILE: tb/fwrs_checker.sv
// Checker for the statistics queue: watches the item and result channels,
// predicts every result beat and compares it field by field.
// Depends on fwrs_pkg and the channel interfaces in fwrs_if.
module fwrs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwrs_in_if          item_i,
  fwrs_out_if         result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fwrs_pkg::*;

  // One result beat as the block reports it.
  typedef struct {
    status_e                status;
    logic signed [ValW-1:0] popped;
    logic        [CntW-1:0] count;
    logic signed [SumW-1:0] sum;
    logic signed [ValW-1:0] mean;
    logic signed [ValW-1:0] largest;
    logic signed [ValW-1:0] smallest;
  } stats_t;

  // Shadow copy of the queue contents and its running sum.
  logic signed [ValW-1:0] shadow_slots [Depth];
  logic [AddrW-1:0]       shadow_head;
  logic [AddrW-1:0]       shadow_tail;
  int                     shadow_count;
  int                     shadow_sum;

  stats_t      expected_stats_q[$];
  int unsigned mismatches;
  int unsigned results_seen;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  // Applies one item to the shadow queue and returns the statistics it yields.
  function automatic stats_t apply_item(input opcode_e op,
                                        input logic signed [ValW-1:0] val);
    stats_t           r;
    logic [AddrW-1:0] idx;
    r.status = StOk;
    r.popped = '0;
    if (op == OpPush) begin
      if (shadow_count >= Depth) begin
        r.status = StFull;
      end else begin
        shadow_slots[shadow_tail] = val;
        shadow_tail++;
        shadow_count++;
        shadow_sum += val;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = StEmpty;
      end else begin
        r.popped = shadow_slots[shadow_head];
        shadow_head++;
        shadow_count--;
        shadow_sum -= r.popped;
        if (shadow_count == 0) shadow_sum = 0;
      end
    end

    // Largest and smallest come from a full walk over the held entries.
    r.largest  = '0;
    r.smallest = '0;
    if (shadow_count > 0) begin
      r.largest  = shadow_slots[shadow_head];
      r.smallest = shadow_slots[shadow_head];
      for (int i = 1; i < shadow_count; i++) begin
        idx = shadow_head + AddrW'(i);
        if (shadow_slots[idx] > r.largest)  r.largest  = shadow_slots[idx];
        if (shadow_slots[idx] < r.smallest) r.smallest = shadow_slots[idx];
      end
    end

    // Integer division in SystemVerilog truncates toward zero.
    r.count = CntW'(shadow_count);
    r.sum   = (shadow_count != 0) ? SumW'(shadow_sum) : '0;
    r.mean  = (shadow_count != 0) ? ValW'(shadow_sum / shadow_count) : '0;
    return r;
  endfunction

  // Predict on every accepted item beat, compare on every accepted result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t got;
    stats_t want;
    if (!rst_ni) begin
      shadow_head  = '0;
      shadow_tail  = '0;
      shadow_count = 0;
      shadow_sum   = 0;
      expected_stats_q.delete();
      mismatches   = 0;
      results_seen = 0;
      pending_o   <= 0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        expected_stats_q.push_back(apply_item(item_i.opcode, item_i.value));
      end
      if (result_i.valid && result_i.ready) begin
        got.status   = result_i.status;
        got.popped   = result_i.popped_value;
        got.count    = result_i.item_count;
        got.sum      = result_i.total_sum;
        got.mean     = result_i.mean_value;
        got.largest  = result_i.largest;
        got.smallest = result_i.smallest;
        if (expected_stats_q.size() == 0) begin
          report_mismatch("result beat with no item waiting for it");
        end else begin
          want = expected_stats_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
          if (got.popped !== want.popped)
            report_mismatch($sformatf("popped_value got %0d expected %0d",
                                      got.popped, want.popped));
          if (got.count !== want.count)
            report_mismatch($sformatf("item_count got %0d expected %0d",
                                      got.count, want.count));
          if (got.sum !== want.sum)
            report_mismatch($sformatf("total_sum got %0d expected %0d",
                                      got.sum, want.sum));
          if (got.mean !== want.mean)
            report_mismatch($sformatf("mean_value got %0d expected %0d",
                                      got.mean, want.mean));
          if (got.largest !== want.largest)
            report_mismatch($sformatf("largest got %0d expected %0d",
                                      got.largest, want.largest));
          if (got.smallest !== want.smallest)
            report_mismatch($sformatf("smallest got %0d expected %0d",
                                      got.smallest, want.smallest));
        end
        results_seen++;
      end
      pending_o <= expected_stats_q.size();
    end
  end

endmodule

FILE: tb/fifo_with_running_statistics_tb.sv
// Top of the testbench: clock, reset, item and result traffic for the
// statistics queue, and the verdict. Depends on fwrs_pkg, fwrs_if, fwrs_checker.
module fifo_with_running_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwrs_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  fwrs_in_if  item_if ();
  fwrs_out_if result_if ();

  fifo_with_running_statistics dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (result_if)
  );

  fwrs_checker u_stats_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung block.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Value mix: extremes, small magnitudes and full-range noise.
  function automatic logic signed [ValW-1:0] rand_q88();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $signed(16'($urandom_range(511))) - 16'sd256;
      default: return ValW'($urandom());
    endcase
  endfunction

  // Sends one item beat, with random idle cycles ahead of it.
  task automatic issue_item(input opcode_e op, input logic signed [ValW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid  <= 1'b1;
    item_if.opcode <= op;
    item_if.value  <= val;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_results_done();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // A run of identical operations; pops carry random don't-care values.
  task automatic op_burst(input opcode_e op, input int n,
                          input logic signed [ValW-1:0] val);
    repeat (n) issue_item(op, (op == OpPush) ? val : rand_q88());
  endtask

  // Random bursts that walk the fill level between empty and full.
  task automatic random_traffic(input int n);
    int      done_items;
    int      kind;
    int      len;
    opcode_e op;
    done_items = 0;
    while (done_items < n) begin
      kind = $urandom_range(2);
      len  = (kind == 2) ? $urandom_range(1, 20) : $urandom_range(1, 70);
      if (len > n - done_items) len = n - done_items;
      repeat (len) begin
        case (kind)
          0:       op = ($urandom_range(9) != 0) ? OpPush : OpPop;
          1:       op = ($urandom_range(9) != 0) ? OpPop : OpPush;
          default: op = $urandom_range(1) ? OpPop : OpPush;
        endcase
        issue_item(op, rand_q88());
        if ($urandom_range(39) == 0) wait_results_done();
      end
      done_items += len;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    item_if.valid    = 1'b0;
    item_if.opcode   = OpPush;
    item_if.value    = '0;
    result_if.ready  = 1'b0;
    send_idle_pct    = 37;
    recv_idle_pct    = 65;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, extremes, removal of the extremes, drain past empty.
    issue_item(OpPop,  16'sh1234);
    issue_item(OpPush, 16'sh7FFF);
    issue_item(OpPush, 16'sh8000);
    issue_item(OpPush, 16'sh0000);
    issue_item(OpPush, -16'sd1);
    issue_item(OpPush, 16'sh0001);
    issue_item(OpPush, 16'sh0100);
    op_burst(OpPop, 7, '0);
    issue_item(OpPush, 16'sh8000);
    issue_item(OpPop,  16'shFFFF);
    issue_item(OpPush, 16'sh5555);
    issue_item(OpPush, 16'shAAAA);
    issue_item(OpPush, -16'sd3);
    op_burst(OpPop, 3, '0);
    random_traffic(150);
    wait_results_done();

    // Second phase: the other idling mix, then empty, fill at the top value.
    send_idle_pct = 65;
    recv_idle_pct = 37;
    random_traffic(60);
    op_burst(OpPop, 66, '0);
    op_burst(OpPush, 66, 16'sh7FFF);
    op_burst(OpPop, 66, '0);
    wait_results_done();

    // Third phase: no idling; fill at the bottom value, drain, then random.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    op_burst(OpPush, 66, 16'sh8000);
    op_burst(OpPop, 66, '0);
    random_traffic(100);

    // Let the last results drain, then give the verdict.
    wait_results_done();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
